/* hw/rtl/fstk_pkg.sv */
`default_nettype none

package fstk_pkg;

  // Defaults for the top-level parameters.
  localparam int ENTRIES_DEF    = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed widths of the channel fields and of the push sequence counter.
  localparam int WORD_BITS = 32;
  localparam int SEQ_BITS  = 32;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/fstk_if.sv */
`default_nettype none

interface fstk_in_if import fstk_pkg::*; ();
  logic                        valid;
  logic                        ready;
  kind_t                       kind;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fstk_out_if import fstk_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] popped_value;
  status_t                     status;

  modport source (output valid, output popped_value, output status, input ready);
  modport sink   (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fstk_ram.sv */
`default_nettype none

module fstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/frequency_stack.sv */
`default_nettype none

// Maximum-frequency stack. A push word stores the value together with its running count and
// a sequence number; a pop word removes the entry with the highest count (latest push on a
// tie) and returns its value. Pop on empty answers status EMPTY, push on full answers status
// FULL, and neither changes anything. After reset the block clears every entry of its two
// RAMs before it raises in_ch.ready. A push or a pop makes one sweep over the entry and
// count RAMs through their single read ports; error answers found from the held count skip
// the sweep. One word is in work at a time, and the next word is taken while the previous
// result still waits in the output register.
module frequency_stack import fstk_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  fstk_in_if.sink      in_ch,
  fstk_out_if.source   out_ch
);

  localparam int AW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef struct packed {
    logic                  vld;
    logic [FW-1:0]         freq;
    logic [SEQ_BITS-1:0]   seq;
    logic [AW-1:0]         cslot;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

  typedef struct packed {
    logic [FW-1:0]         cnt;
    logic [VALUE_BITS-1:0] val;
  } count_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PUSH_WR,
    S_POP_RD,
    S_POP_WR,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic                  issue_r, issue_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  found_e_r, found_e_nxt;
  logic [AW-1:0]         e_idx_r, e_idx_nxt;
  logic                  found_m_r, found_m_nxt;
  logic [AW-1:0]         m_idx_r, m_idx_nxt;
  logic [FW-1:0]         m_cnt_r, m_cnt_nxt;
  logic                  found_fc_r, found_fc_nxt;
  logic [AW-1:0]         fc_idx_r, fc_idx_nxt;
  logic                  best_vld_r, best_vld_nxt;
  logic [AW-1:0]         best_idx_r, best_idx_nxt;
  logic [FW-1:0]         best_freq_r, best_freq_nxt;
  logic [SEQ_BITS-1:0]   best_seq_r, best_seq_nxt;
  logic [VALUE_BITS-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]         best_cs_r, best_cs_nxt;
  logic [FW-1:0]         held_r, held_nxt;
  logic [SEQ_BITS-1:0]   seq_r, seq_nxt;
  logic [WORD_BITS-1:0]  res_val_r, res_val_nxt;
  status_t               res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]  out_val_r, out_val_nxt;
  status_t               out_st_r, out_st_nxt;

  logic                  e_we, c_we;
  logic [AW-1:0]         e_waddr, c_waddr, c_raddr;
  entry_t                e_wdata, e_rd;
  count_t                c_wdata, c_rd;
  logic [$bits(entry_t)-1:0] e_rdata;
  logic [$bits(count_t)-1:0] c_rdata;

  logic [VALUE_BITS+WORD_BITS-1:0] in_ext, pop_ext;
  logic [VALUE_BITS-1:0]           in_val;
  logic [FW-1:0]                   new_cnt;
  logic [AW-1:0]                   new_cslot;

  assign in_ext  = {{VALUE_BITS{1'b0}}, in_ch.value};
  assign in_val  = in_ext[VALUE_BITS-1:0];
  assign pop_ext = {{WORD_BITS{1'b0}}, best_val_r};
  assign e_rd    = entry_t'(e_rdata);
  assign c_rd    = count_t'(c_rdata);

  assign new_cnt   = found_m_r ? m_cnt_r + FW'(1) : FW'(1);
  assign new_cslot = found_m_r ? m_idx_r : fc_idx_r;

  fstk_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
    .clk     (clk),
    .wr_en   (e_we),
    .wr_addr (e_waddr),
    .wr_data (e_wdata),
    .rd_addr (addr_r),
    .rd_data (e_rdata)
  );

  fstk_ram #(.WIDTH($bits(count_t)), .DEPTH(ENTRIES)) u_count_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_addr (c_raddr),
    .rd_data (c_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = addr_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    found_e_nxt   = found_e_r;
    e_idx_nxt     = e_idx_r;
    found_m_nxt   = found_m_r;
    m_idx_nxt     = m_idx_r;
    m_cnt_nxt     = m_cnt_r;
    found_fc_nxt  = found_fc_r;
    fc_idx_nxt    = fc_idx_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_freq_nxt = best_freq_r;
    best_seq_nxt  = best_seq_r;
    best_val_nxt  = best_val_r;
    best_cs_nxt   = best_cs_r;
    held_nxt      = held_r;
    seq_nxt       = seq_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    e_we          = 1'b0;
    e_waddr       = addr_r;
    e_wdata       = '0;
    c_we          = 1'b0;
    c_waddr       = addr_r;
    c_wdata       = '0;
    c_raddr       = addr_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // A zero word marks an entry as free and a count slot as unused.
        e_we = 1'b1;
        c_we = 1'b1;
        if (addr_r == LAST) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          val_nxt     = in_val;
          res_val_nxt = '0;
          if (in_ch.kind == KIND_PUSH && held_r == FW'(ENTRIES)) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_EMIT;
          end else if (in_ch.kind == KIND_POP && held_r == '0) begin
            res_st_nxt = ST_EMPTY;
            state_nxt  = S_EMIT;
          end else begin
            addr_nxt     = '0;
            issue_nxt    = 1'b1;
            found_e_nxt  = 1'b0;
            found_m_nxt  = 1'b0;
            found_fc_nxt = 1'b0;
            best_vld_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = addr_r;
          if (addr_r == LAST) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
        if (rd_vld_r) begin
          if (kind_r == KIND_PUSH) begin
            if (!found_e_r && !e_rd.vld) begin
              found_e_nxt = 1'b1;
              e_idx_nxt   = rd_idx_r;
            end
            if (!found_m_r && c_rd.cnt != '0 && c_rd.val == val_r) begin
              found_m_nxt = 1'b1;
              m_idx_nxt   = rd_idx_r;
              m_cnt_nxt   = c_rd.cnt;
            end
            if (!found_fc_r && c_rd.cnt == '0) begin
              found_fc_nxt = 1'b1;
              fc_idx_nxt   = rd_idx_r;
            end
          end else begin
            // Strict compares keep the lowest index when count and sequence both tie.
            if (e_rd.vld && (!best_vld_r || e_rd.freq > best_freq_r ||
                (e_rd.freq == best_freq_r && e_rd.seq > best_seq_r))) begin
              best_vld_nxt  = 1'b1;
              best_idx_nxt  = rd_idx_r;
              best_freq_nxt = e_rd.freq;
              best_seq_nxt  = e_rd.seq;
              best_val_nxt  = e_rd.val;
              best_cs_nxt   = e_rd.cslot;
            end
          end
          if (rd_idx_r == LAST) begin
            state_nxt = (kind_r == KIND_PUSH) ? S_PUSH_WR : S_POP_RD;
          end
        end
      end

      S_PUSH_WR: begin
        res_val_nxt = '0;
        state_nxt   = S_EMIT;
        if (!found_e_r || (!found_m_r && !found_fc_r)) begin
          res_st_nxt = ST_FULL;
        end else begin
          c_we          = 1'b1;
          c_waddr       = new_cslot;
          c_wdata.cnt   = new_cnt;
          c_wdata.val   = val_r;
          e_we          = 1'b1;
          e_waddr       = e_idx_r;
          e_wdata.vld   = 1'b1;
          e_wdata.freq  = new_cnt;
          e_wdata.seq   = seq_r;
          e_wdata.cslot = new_cslot;
          e_wdata.val   = val_r;
          seq_nxt       = seq_r + SEQ_BITS'(1);
          held_nxt      = held_r + FW'(1);
          res_st_nxt    = ST_OK;
        end
      end

      S_POP_RD: begin
        if (!best_vld_r) begin
          // The held count disagrees with the valid bits: resynchronize to empty.
          held_nxt    = '0;
          seq_nxt     = '0;
          res_val_nxt = '0;
          res_st_nxt  = ST_EMPTY;
          state_nxt   = S_EMIT;
        end else begin
          e_we      = 1'b1;
          e_waddr   = best_idx_r;
          c_raddr   = best_cs_r;
          state_nxt = S_POP_WR;
        end
      end

      S_POP_WR: begin
        if (c_rd.cnt != '0) begin
          c_we        = 1'b1;
          c_waddr     = best_cs_r;
          c_wdata.cnt = c_rd.cnt - FW'(1);
          c_wdata.val = c_rd.val;
        end
        held_nxt = held_r - FW'(1);
        if (held_r == FW'(1)) begin
          seq_nxt = '0;
        end
        res_val_nxt = pop_ext[WORD_BITS-1:0];
        res_st_nxt  = ST_OK;
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      held_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      held_r      <= held_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r    <= rd_idx_nxt;
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    found_e_r   <= found_e_nxt;
    e_idx_r     <= e_idx_nxt;
    found_m_r   <= found_m_nxt;
    m_idx_r     <= m_idx_nxt;
    m_cnt_r     <= m_cnt_nxt;
    found_fc_r  <= found_fc_nxt;
    fc_idx_r    <= fc_idx_nxt;
    best_vld_r  <= best_vld_nxt;
    best_idx_r  <= best_idx_nxt;
    best_freq_r <= best_freq_nxt;
    best_seq_r  <= best_seq_nxt;
    best_val_r  <= best_val_nxt;
    best_cs_r   <= best_cs_nxt;
    res_val_r   <= res_val_nxt;
    res_st_r    <= res_st_nxt;
    out_val_r   <= out_val_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_val_r;
  assign out_ch.status       = out_st_r;

endmodule

`default_nettype wire

/* hw/rtl/fstk_checker.sv */
`default_nettype none

module fstk_checker import fstk_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_popped_value,
  input status_t              out_status
);

  // Words taken in but whose result has not yet been handed over.
  logic [2:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pend_nxt = pend_r + 3'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value) && $stable(out_status))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_popped_value == '0)
    else $error("error result carries a nonzero value");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more than two words outstanding");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result shown with no word outstanding");

endmodule

bind frequency_stack fstk_checker u_fstk_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_popped_value (out_ch.popped_value),
  .out_status       (out_ch.status)
);

`default_nettype wire

/* bench/tb_frequency_stack.sv */
module tb_frequency_stack;
  import fstk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = ENTRIES_DEF;
  localparam int RANDOM_WORDS  = 1800;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLDOFF_AFTER = 300;
  localparam int HOLDOFF_SPAN  = 2500;
  localparam int TAIL_CYCLES   = 300;

  typedef struct packed {
    logic [WORD_BITS-1:0] popped;
    status_t              status;
  } outcome_t;

  typedef struct {
    kind_t                kind;
    logic [WORD_BITS-1:0] value;
    bit                   typed;
    outcome_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  fstk_in_if  in_ch ();
  fstk_out_if out_ch ();

  frequency_stack dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the stack: stored entries and the per-value count table.
  logic [WORD_BITS-1:0] slot_value [DEPTH];
  logic [6:0]           slot_freq  [DEPTH];
  logic [SEQ_BITS-1:0]  slot_seq   [DEPTH];
  bit                   slot_used  [DEPTH];
  logic [WORD_BITS-1:0] tally_value[DEPTH];
  logic [6:0]           tally_count[DEPTH];
  logic [6:0]           held;
  logic [SEQ_BITS-1:0]  seq_next;

  outcome_t pending_results[$];
  outcome_t head_result;
  int       fail_count   = 0;
  int       results_seen = 0;
  int       idle_cycles  = 0;
  int       random_sent  = 0;
  int       burst_left   = 0;

  logic [WORD_BITS-1:0] value_pool[6];
  int                   pool_size;
  logic [WORD_BITS-1:0] extremes[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0001};

  row_t directed_rows[23] = '{
    '{KIND_POP,  32'h1234_5678, 1'b1, '{32'h0, ST_EMPTY}},
    '{KIND_PUSH, 32'h8000_0000, 1'b1, '{32'h0, ST_OK}},
    '{KIND_POP,  32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY}},
    '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'h0000_0000, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'hAAAA_AAAA, 1'b0, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'h0000_0000, 1'b1, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h5555_5555, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY}},
    '{KIND_PUSH, 32'h0000_0001, 1'b1, '{32'h0, ST_OK}},
    '{KIND_PUSH, 32'h8000_0000, 1'b1, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}},
    '{KIND_POP,  32'h0000_0000, 1'b0, '{32'h0, ST_OK}}
  };

  // Applies one word to the shadow stack and returns the answer it calls for.
  function automatic outcome_t stack_apply(kind_t k, logic [WORD_BITS-1:0] v);
    outcome_t r;
    int e;
    int c;
    int best;
    r.popped = '0;
    r.status = ST_OK;
    if (k == KIND_PUSH) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      e = -1;
      c = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!slot_used[i] && e < 0) e = i;
        if (tally_count[i] != 0 && tally_value[i] == v && c < 0) c = i;
      end
      if (c < 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (tally_count[i] == 0 && c < 0) c = i;
        tally_value[c] = v;
      end
      tally_count[c] = tally_count[c] + 7'd1;
      slot_value[e]  = v;
      slot_freq[e]   = tally_count[c];
      slot_seq[e]    = seq_next;
      slot_used[e]   = 1'b1;
      seq_next       = seq_next + 1;
      held           = held + 7'd1;
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      // Strict comparisons keep the lowest index when count and sequence both tie.
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && (best < 0 || slot_freq[i] > slot_freq[best] ||
            (slot_freq[i] == slot_freq[best] && slot_seq[i] > slot_seq[best])))
          best = i;
      end
      r.popped = slot_value[best];
      slot_used[best] = 1'b0;
      held = held - 7'd1;
      for (int i = 0; i < DEPTH; i++) begin
        if (tally_count[i] != 0 && tally_value[i] == r.popped) begin
          tally_count[i] = tally_count[i] - 7'd1;
          break;
        end
      end
      if (held == 0) seq_next = '0;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_word(kind_t k, logic [WORD_BITS-1:0] v, bit typed, outcome_t want);
    outcome_t r;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = stack_apply(k, v);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic sender_idle();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic refresh_pool();
    pool_size = $urandom_range(1, 6);
    for (int i = 0; i < pool_size; i++)
      value_pool[i] = ($urandom_range(0, 2) == 0) ? extremes[$urandom_range(0, 4)]
                                                 : $urandom();
  endtask

  task automatic issue(kind_t k);
    logic [WORD_BITS-1:0] v;
    outcome_t none;
    none = '0;
    if (k == KIND_PUSH && $urandom_range(0, 99) < 85)
      v = value_pool[$urandom_range(0, pool_size - 1)];
    else
      v = $urandom();
    drive_word(k, v, 1'b0, none);
    random_sent++;
    sender_idle();
  endtask

  // Sender: reset, the directed table, then fill, drain and mixed phases.
  initial begin
    int hits;
    int target;
    int span;
    int phase;
    kind_t k;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_PUSH;
    in_ch.value = '0;
    rst_n = 1'b0;
    held = '0;
    seq_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i]   = 1'b0;
      tally_count[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].kind, directed_rows[i].value,
                 directed_rows[i].typed, directed_rows[i].want);
      sender_idle();
    end
    drain_wait();

    while (random_sent < RANDOM_WORDS) begin
      refresh_pool();
      phase = $urandom_range(0, 9);
      hits = 0;
      target = $urandom_range(1, 3);
      if (phase < 4) begin
        // Fill until pushes on a full stack have been refused one to three times.
        while (hits < target) begin
          k = ($urandom_range(0, 99) < 88) ? KIND_PUSH : KIND_POP;
          if (k == KIND_PUSH && held == DEPTH) hits++;
          issue(k);
        end
      end else if (phase < 7) begin
        while (hits < target) begin
          k = ($urandom_range(0, 99) < 85) ? KIND_POP : KIND_PUSH;
          if (k == KIND_POP && held == 0) hits++;
          issue(k);
        end
      end else begin
        span = $urandom_range(20, 80);
        repeat (span) issue($urandom_range(0, 1) ? KIND_POP : KIND_PUSH);
      end
      if ($urandom_range(0, 4) == 0) drain_wait();
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("frequency_stack regression: pass");
    end else begin
      $display("frequency_stack regression: fail");
    end
    $finish;
  end

  // Receiver: stall modes in windows of random length, and one long hold-off.
  initial begin
    int mode;
    int span;
    bit held_off;
    held_off = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && results_seen >= HOLDOFF_AFTER) begin
        held_off = 1'b1;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_SPAN) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int j = 0; j < span; j++) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (j % 5) < 2;
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: popped_value %h status %0d",
               out_ch.popped_value, out_ch.status);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_ch.popped_value !== head_result.popped) begin
          $error("popped_value: expected %h, got %h", head_result.popped,
                 out_ch.popped_value);
          fail_count++;
        end
        if (out_ch.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("frequency_stack regression: fail");
      $finish;
    end
  end

endmodule
